[rtl/cfwc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfwc_pkg: shared types and constants of the frame window cache
// Field widths, operation codes and the per-item result record.
// ----------------------------------------------------------------------------
package cfwc_pkg;

	localparam int POS_W    = 31;   // frame position
	localparam int HDL_W    = 32;   // handle as seen on the ports
	localparam int CNT_W    = 7;    // count, capacity and ring slot
	localparam int MODE_W   = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUT   = 2'd0,
		MODE_GET   = 2'd1,
		MODE_PURGE = 2'd2
	} mode_t;

	// Per-item result, minus the handle which comes from the ring read port.
	typedef struct packed {
		logic             hit;
		logic             get_hit;
		logic             inserted;
		logic [CNT_W-1:0] count;
		logic             nonempty;
		logic [POS_W-1:0] earliest;
		logic [POS_W-1:0] latest;
	} res_t;

endpackage

[rtl/cfwc_ring.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfwc_ring: handle storage
// Single-port ring memory, one write or one registered read per cycle.
// ----------------------------------------------------------------------------
module cfwc_ring #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic                       re,
	input  logic [AW-1:0]              addr,
	input  logic [cfwc_pkg::HDL_W-1:0] wdata,
	output logic [cfwc_pkg::HDL_W-1:0] rdata
);

	logic [WIDTH-1:0]                 mem [DEPTH];
	logic [WIDTH-1:0]                 rd_q;
	logic [WIDTH+cfwc_pkg::HDL_W-1:0] wr_ext;
	logic [WIDTH+cfwc_pkg::HDL_W-1:0] rd_ext;

	// Fit the port handle to the stored width and back again.
	assign wr_ext = {{WIDTH{1'b0}}, wdata};
	assign rd_ext = {{cfwc_pkg::HDL_W{1'b0}}, rd_q};
	assign rdata  = rd_ext[cfwc_pkg::HDL_W-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wr_ext[WIDTH-1:0];
		end
		if (re) begin
			rd_q <= mem[addr];
		end
	end

endmodule

[rtl/cfwc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfwc_ctrl: window state and per-item decision
// Holds first position, start slot, count and capacity; decides each item.
// ----------------------------------------------------------------------------
module cfwc_ctrl #(
	parameter int RING_DEPTH = 64,
	localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [cfwc_pkg::CNT_W-1:0]  cfg_data,
	input  logic                        step,
	input  cfwc_pkg::mode_t             mode,
	input  logic [cfwc_pkg::POS_W-1:0]  position,
	output cfwc_pkg::res_t              res,
	output logic                        ring_we,
	output logic                        ring_re,
	output logic [AW-1:0]               ring_addr
);

	localparam int CW = cfwc_pkg::CNT_W;
	localparam int PW = cfwc_pkg::POS_W;
	localparam int CAP_RESET = (RING_DEPTH < 64) ? RING_DEPTH : 64;

	logic [CW-1:0] cap_q, held_q, start_q;
	logic [PW-1:0] first_q;
	logic [CW-1:0] held_d, start_d;
	logic [PW-1:0] first_d;
	logic [CW-1:0] cap_clamped;

	logic [PW:0]   off, app_pos;
	logic          in_win, is_next;
	logic [CW:0]   win_sum, app_sum, win_red, app_red, start_inc;
	logic [CW-1:0] slot;
	logic [AW+CW-1:0] slot_ext;
	logic [PW:0]   last_pos;

	// Clamp a written capacity to 1..RING_DEPTH.
	always_comb begin
		if (cfg_data == '0) begin
			cap_clamped = CW'(1);
		end else if (32'(cfg_data) > RING_DEPTH) begin
			cap_clamped = CW'(RING_DEPTH);
		end else begin
			cap_clamped = cfg_data;
		end
	end

	// Window lookup and sequence test.
	assign off     = {1'b0, position} - {1'b0, first_q};
	assign in_win  = (held_q != '0) && (position >= first_q)
		&& (off < {{(PW+1-CW){1'b0}}, held_q});
	assign app_pos = {1'b0, first_q} + {{(PW+1-CW){1'b0}}, held_q};
	assign is_next = (held_q != '0) && ({1'b0, position} == app_pos);

	// Slot arithmetic: both sums stay below twice the capacity.
	assign win_sum   = {1'b0, start_q} + {1'b0, off[CW-1:0]};
	assign app_sum   = {1'b0, start_q} + {1'b0, held_q};
	assign win_red   = (win_sum >= {1'b0, cap_q}) ? win_sum - {1'b0, cap_q} : win_sum;
	assign app_red   = (app_sum >= {1'b0, cap_q}) ? app_sum - {1'b0, cap_q} : app_sum;
	assign start_inc = {1'b0, start_q} + (CW+1)'(1);

	always_comb begin
		held_d        = held_q;
		start_d       = start_q;
		first_d       = first_q;
		slot          = start_q;
		ring_we       = 1'b0;
		ring_re       = 1'b0;
		res.hit       = 1'b0;
		res.get_hit   = 1'b0;
		res.inserted  = 1'b0;
		unique case (mode)
			cfwc_pkg::MODE_PUT: begin
				if (in_win) begin
					res.hit = 1'b1;
				end else if (is_next) begin
					res.inserted = 1'b1;
					ring_we      = step;
					if (held_q < cap_q) begin
						slot   = app_red[CW-1:0];
						held_d = held_q + CW'(1);
					end else begin
						// Ring full: overwrite the oldest and slide the window.
						slot    = start_q;
						start_d = (start_inc == {1'b0, cap_q}) ? '0 : start_inc[CW-1:0];
						first_d = first_q + PW'(1);
					end
				end else begin
					// Out of sequence: restart the window at this position.
					res.inserted = 1'b1;
					ring_we      = step;
					slot         = start_q;
					first_d      = position;
					held_d       = CW'(1);
				end
			end
			cfwc_pkg::MODE_GET: begin
				if (in_win) begin
					res.hit     = 1'b1;
					res.get_hit = 1'b1;
					ring_re     = step;
					slot        = win_red[CW-1:0];
				end
			end
			cfwc_pkg::MODE_PURGE: begin
				held_d = '0;
			end
			default: begin
			end
		endcase
		last_pos     = {1'b0, first_d} + {{(PW+1-CW){1'b0}}, held_d} - (PW+1)'(1);
		res.count    = held_d;
		res.nonempty = (held_d != '0);
		res.earliest = res.nonempty ? first_d : '0;
		res.latest   = res.nonempty ? last_pos[PW-1:0] : '0;
	end

	assign slot_ext  = {{AW{1'b0}}, slot};
	assign ring_addr = slot_ext[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CW'(CAP_RESET);
			held_q  <= '0;
			start_q <= '0;
			first_q <= '0;
		end else if (cfg_we) begin
			cap_q   <= cap_clamped;
			held_q  <= '0;
			start_q <= '0;
		end else if (step) begin
			held_q  <= held_d;
			start_q <= start_d;
			first_q <= first_d;
		end
	end

	a_held_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= cap_q) else $error("count above capacity");

	a_start_lt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		start_q < cap_q) else $error("start slot outside ring");

	a_cap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cap_q != '0) && (32'(cap_q) <= RING_DEPTH)) else $error("capacity out of range");

	a_cfg_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (held_q == '0) && (start_q == '0)) else $error("config did not empty cache");

endmodule

[rtl/consecutive_frame_window_cache.sv]
`timescale 1ns / 1ps
// Path: an accepted item enters the input register, then the result register that
//   drives m_axis; it waits while that register holds a result m_axis has not taken.
// Throughput: one item per cycle while m_axis_tready stays high; the window state
//   updates as an item leaves the input register; the ring takes at most one access.
// Reset (arst_n low, asynchronous): cache empty, start slot and first position zero,
//   capacity min(64, RING_DEPTH); ring contents stay unknown until written.
// ----------------------------------------------------------------------------
// consecutive_frame_window_cache: ring cache of frame handles
// Keeps handles for a run of consecutive positions; put, get and purge items
// each give one result with the count and the window bounds.
// ----------------------------------------------------------------------------
module consecutive_frame_window_cache #(
	parameter int RING_DEPTH   = 64,
	parameter int HANDLE_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	// capacity register write
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [6:0]   cfg_data,      // capacity_in_use
	// items in
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,  // position[30:0], frame_handle[62:31], zero[63]
	input  logic [1:0]   s_axis_tuser,  // mode[1:0]
	// results out
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [103:0] m_axis_tdata   // hit[0], found_handle[32:1], inserted[33],
	                                    // entry_count[40:34], nonempty[41],
	                                    // earliest_position[72:42], latest_position[103:73]
);

	localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int PW = cfwc_pkg::POS_W;
	localparam int HW = cfwc_pkg::HDL_W;

	// Input register: one item waiting for its turn at the window logic.
	logic                  valid_s1;
	cfwc_pkg::mode_t       mode_s1;
	logic [PW-1:0]         pos_s1;
	logic [HW-1:0]         handle_s1;

	// Result register.
	logic                  valid_s2;
	cfwc_pkg::res_t        res_s2;

	logic                  adv_s1;
	logic                  cfg_we;
	cfwc_pkg::res_t        res;
	logic                  ring_we, ring_re;
	logic [AW-1:0]         ring_addr;
	logic [HW-1:0]         ring_rdata;
	logic [HW-1:0]         found;

	// Configuration is always taken; the user ensures the block is idle (not checked).
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid;

	// Advance the input stage when the result register is free or being drained.
	assign adv_s1        = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Payload: load on accept, hold otherwise.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			mode_s1   <= cfwc_pkg::mode_t'(s_axis_tuser);
			pos_s1    <= s_axis_tdata[30:0];
			handle_s1 <= s_axis_tdata[62:31];
		end
	end

	cfwc_ctrl #(
		.RING_DEPTH (RING_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.step      (adv_s1),
		.mode      (mode_s1),
		.position  (pos_s1),
		.res       (res),
		.ring_we   (ring_we),
		.ring_re   (ring_re),
		.ring_addr (ring_addr)
	);

	// Ring read data is registered alongside the result register.
	cfwc_ring #(
		.DEPTH (RING_DEPTH),
		.WIDTH (HANDLE_WIDTH)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.re    (ring_re),
		.addr  (ring_addr),
		.wdata (handle_s1),
		.rdata (ring_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= adv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	// Show the stored handle only for a get that hit; zero otherwise.
	assign found = res_s2.get_hit ? ring_rdata : '0;

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {res_s2.latest, res_s2.earliest, res_s2.nonempty,
		res_s2.count, res_s2.inserted, found, res_s2.hit};

	a_get_not_insert: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.get_hit && res_s2.inserted))
		else $error("get and insert in one item");

	a_get_hit_is_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.get_hit) |-> res_s2.hit)
		else $error("handle returned without hit");

	a_single_ring_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(ring_we && ring_re)) else $error("ring read and write together");

endmodule
